// ===== rtl/tfd_pkg.sv =====
// Shared types and constants of the tank fill and dose sequencer.
package tfd_pkg;

  localparam int ACT_W   = 2;
  localparam int LEVEL_W = 12;
  localparam int ML_W    = 16;
  localparam int TIME_W  = 32;
  localparam int PUMP_W  = 3;
  localparam int STAT_W  = 3;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 24;
  localparam int FILL_W  = 24;
  localparam int DUR_W   = 25;

  localparam logic [ACT_W-1:0] ACT_TICK      = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FILL      = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FILL_DOSE = 2'd2;
  localparam logic [ACT_W-1:0] ACT_DOSE      = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_BUSY      = 3'd1;
  localparam logic [STAT_W-1:0] ST_BAD_LEVEL = 3'd2;
  localparam logic [STAT_W-1:0] ST_SMALL     = 3'd3;
  localparam logic [STAT_W-1:0] ST_SERVER    = 3'd4;
  localparam logic [STAT_W-1:0] ST_TIMEOUT   = 3'd5;

  localparam logic [CIDX_W-1:0] REG_HEIGHT   = 3'd0;
  localparam logic [CIDX_W-1:0] REG_MAX_FILL = 3'd1;
  localparam logic [CIDX_W-1:0] REG_ML_PER_L = 3'd2;
  localparam logic [CIDX_W-1:0] REG_DEAD     = 3'd3;
  localparam logic [CIDX_W-1:0] REG_MS_PER_ML = 3'd4;

  // multiplier operand and product widths
  localparam int OPA_W  = 21;
  localparam int OPB_W  = 22;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int UNIT_W = 37;
  localparam int XQ_W   = 23;

  // volume in 1/1600 l: 332*level - 6608
  localparam logic [OPB_W-1:0] VOL_SLOPE  = 22'd332;
  localparam logic [OPA_W-1:0] VOL_OFFSET = 21'd6608;
  // division by 409600 = shift by 14, then reciprocal of 25
  localparam int               UNIT_SHIFT = 14;
  localparam logic [OPB_W-1:0] RECIP_25   = 22'd2684355;
  localparam int               RECIP_SH   = 26;
  localparam logic [XQ_W-1:0]  SAT_LIMIT  = 23'd1638375;
  localparam logic [ML_W-1:0]  DOSE_MIN   = 16'd30;
  localparam int               DUR_SHIFT  = 8;

endpackage

// ===== rtl/tfd_if.sv =====
// Channel interfaces: command, response and configuration write.
interface tfd_cmd_if import tfd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [LEVEL_W-1:0] level;
  logic [LEVEL_W-1:0] target_level;
  logic [ML_W-1:0]    dose_amount;
  logic [TIME_W-1:0]  now_ms;
  logic               server_ok;
  modport source (output valid, action, level, target_level, dose_amount, now_ms, server_ok,
                  input ready);
  modport sink (input valid, action, level, target_level, dose_amount, now_ms, server_ok,
                output ready);
endinterface

interface tfd_rsp_if import tfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              valve_open;
  logic              filling;
  logic              dosing;
  logic              pump_on;
  logic [PUMP_W-1:0] pump_number;
  logic [STAT_W-1:0] status;
  logic [ML_W-1:0]   dose_ml;
  modport source (output valid, valve_open, filling, dosing, pump_on, pump_number, status,
                  dose_ml, input ready);
  modport sink (input valid, valve_open, filling, dosing, pump_on, pump_number, status,
                dose_ml, output ready);
endinterface

interface tfd_cfg_if import tfd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CIDX_W-1:0]  index;
  logic [CDATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/tank_fill_and_dose_sequencer_unit.sv =====
// Top level of the tank fill and nutrient dose sequencer.
// One command transaction is taken at a time. A fill or a rejected request goes EVAL,
// DONE; an accepted dose request EVAL, DUR, DONE; a tick EVAL, PUMP, DONE. A tick ending
// a fill-then-dose fill runs VA, UA, VB, UB, DIV, REC, ML, CHK, then DUR if a dose
// starts, then PUMP, DONE. The unit returns to idle as the result is registered and
// takes the next command after that. The longest case is set by the single shared
// 21x22 multiplier, which the dose computation uses up to six times (two volumes, two
// nutrient amounts, the divide-by-25 reciprocal and the pump time). The response register
// lets the next command be taken while the last result waits. A second result holds the
// unit in its last state until the first is taken. Config writes are always ready.
module tank_fill_and_dose_sequencer_unit import tfd_pkg::*; #(
  parameter int NUM_PUMPS = 4
) (
  input logic    clk,
  input logic    rst,
  tfd_cfg_if.sink cfg,
  tfd_cmd_if.sink cmd,
  tfd_rsp_if.source rsp
);

  localparam logic [PUMP_W-1:0] LAST_PUMP = PUMP_W'(NUM_PUMPS - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EVAL = 4'd1;
  localparam logic [3:0] S_VA   = 4'd2;
  localparam logic [3:0] S_UA   = 4'd3;
  localparam logic [3:0] S_VB   = 4'd4;
  localparam logic [3:0] S_UB   = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_REC  = 4'd7;
  localparam logic [3:0] S_ML   = 4'd8;
  localparam logic [3:0] S_CHK  = 4'd9;
  localparam logic [3:0] S_DUR  = 4'd10;
  localparam logic [3:0] S_PUMP = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  logic [3:0] st;

  logic [LEVEL_W-1:0] level_limit;
  logic [FILL_W-1:0]  max_fill_ms;
  logic [ML_W-1:0]    ml_per_liter;
  logic [ML_W-1:0]    dead_time_ms;
  logic [ML_W-1:0]    ms_per_ml;

  logic               fill_busy, dose_after_fill, valve_state, dose_busy, pump_running;
  logic [LEVEL_W-1:0] goal_level, start_level;
  logic [TIME_W-1:0]  fill_start_time, switch_time;
  logic [PUMP_W-1:0]  active_pump;
  logic [DUR_W-1:0]   pump_duration;
  logic [ML_W-1:0]    shown_dose;
  logic [STAT_W-1:0]  status;
  logic               tmo;

  logic [ACT_W-1:0]   c_act;
  logic [LEVEL_W-1:0] c_lvl, c_tgt;
  logic [ML_W-1:0]    c_amt;
  logic [TIME_W-1:0]  c_now;
  logic               c_sok;

  logic [OPA_W-1:0]  op_a;
  logic [OPB_W-1:0]  op_b;
  logic [PROD_W-1:0] prod;
  logic [UNIT_W-1:0] a_units;
  logic [XQ_W-1:0]   xq;
  logic              sat;
  logic [OPA_W-1:0]  vol;

  logic              rsp_valid;
  logic [TIME_W-1:0] fill_elapsed, pump_elapsed;
  logic              fill_late, pump_expired, reach;

  assign cfg.ready = 1'b1;
  assign cmd.ready = (st == S_IDLE);
  assign rsp.valid = rsp_valid;

  assign vol = (prod[OPA_W-1:0] < VOL_OFFSET) ? '0 : prod[OPA_W-1:0] - VOL_OFFSET;
  assign fill_elapsed = c_now - fill_start_time;
  assign pump_elapsed = c_now - switch_time;
  assign fill_late    = fill_elapsed > {{(TIME_W-FILL_W){1'b0}}, max_fill_ms};
  assign pump_expired = pump_elapsed > {{(TIME_W-DUR_W){1'b0}}, pump_duration};
  assign reach        = c_lvl >= goal_level;

  // shared multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (st)
      S_EVAL: begin
        op_a = OPA_W'(c_amt);
        op_b = OPB_W'(ms_per_ml);
      end
      S_VA: begin
        op_a = OPA_W'(c_lvl);
        op_b = VOL_SLOPE;
      end
      S_VB: begin
        op_a = OPA_W'(start_level);
        op_b = VOL_SLOPE;
      end
      S_UA, S_UB: begin
        op_a = vol;
        op_b = OPB_W'(ml_per_liter);
      end
      S_REC: begin
        op_a = xq[OPA_W-1:0];
        op_b = RECIP_25;
      end
      S_CHK: begin
        op_a = OPA_W'(shown_dose);
        op_b = OPB_W'(ms_per_ml);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    if (cmd.valid && cmd.ready) begin
      c_act <= cmd.action;
      c_lvl <= cmd.level;
      c_tgt <= cmd.target_level;
      c_amt <= cmd.dose_amount;
      c_now <= cmd.now_ms;
      c_sok <= cmd.server_ok;
    end
    if (st == S_VB) a_units <= prod[UNIT_W-1:0];
    if (st == S_DIV) begin
      if (a_units > prod[UNIT_W-1:0])
        xq <= XQ_W'((a_units - prod[UNIT_W-1:0]) >> UNIT_SHIFT);
      else
        xq <= '0;
    end
    if (st == S_REC) sat <= (xq >= SAT_LIMIT);
    if (st == S_DONE && (!rsp_valid || rsp.ready)) begin
      rsp.valve_open  <= valve_state;
      rsp.filling     <= fill_busy;
      rsp.dosing      <= dose_busy;
      rsp.pump_on     <= pump_running;
      rsp.pump_number <= pump_running ? active_pump : '0;
      rsp.status      <= status;
      rsp.dose_ml     <= shown_dose;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st               <= S_IDLE;
      level_limit      <= 12'd1600;
      max_fill_ms      <= 24'd600000;
      ml_per_liter     <= 16'd512;
      dead_time_ms     <= 16'd2000;
      ms_per_ml        <= 16'd256;
      fill_busy        <= 1'b0;
      dose_after_fill  <= 1'b0;
      valve_state      <= 1'b0;
      dose_busy        <= 1'b0;
      pump_running     <= 1'b0;
      goal_level       <= '0;
      start_level      <= '0;
      fill_start_time  <= '0;
      switch_time      <= '0;
      active_pump      <= '0;
      pump_duration    <= '0;
      shown_dose       <= '0;
      status           <= ST_OK;
      tmo              <= 1'b0;
      rsp_valid        <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          REG_HEIGHT:    level_limit  <= cfg.data[LEVEL_W-1:0];
          REG_MAX_FILL:  max_fill_ms  <= cfg.data[FILL_W-1:0];
          REG_ML_PER_L:  ml_per_liter <= cfg.data[ML_W-1:0];
          REG_DEAD:      dead_time_ms <= cfg.data[ML_W-1:0];
          REG_MS_PER_ML: ms_per_ml    <= cfg.data[ML_W-1:0];
          default: ;
        endcase
      end

      if (st == S_DONE && (!rsp_valid || rsp.ready)) rsp_valid <= 1'b1;
      else if (rsp.ready) rsp_valid <= 1'b0;

      case (st)
        S_IDLE: begin
          if (cmd.valid) st <= S_EVAL;
        end
        S_EVAL: begin
          case (c_act)
            ACT_FILL, ACT_FILL_DOSE: begin
              st <= S_DONE;
              if (fill_busy) begin
                status <= ST_BUSY;
              end else if (c_tgt < c_lvl || c_tgt > level_limit) begin
                status <= ST_BAD_LEVEL;
              end else begin
                status          <= ST_OK;
                dose_after_fill <= (c_act == ACT_FILL_DOSE);
                fill_busy       <= 1'b1;
                goal_level      <= c_tgt;
              end
            end
            ACT_DOSE: begin
              if (dose_busy) begin
                status <= ST_BUSY;
                st     <= S_DONE;
              end else if (c_amt < DOSE_MIN) begin
                status <= ST_SMALL;
                st     <= S_DONE;
              end else begin
                status    <= ST_OK;
                dose_busy <= 1'b1;
                st        <= S_DUR;
              end
            end
            default: begin
              if (fill_busy && !valve_state) begin
                st <= S_PUMP;
                if (c_sok) begin
                  status          <= ST_OK;
                  valve_state     <= 1'b1;
                  fill_start_time <= c_now;
                  start_level     <= c_lvl;
                end else begin
                  fill_busy <= 1'b0;
                  status    <= ST_SERVER;
                end
              end else if (fill_busy && (reach || fill_late)) begin
                valve_state <= 1'b0;
                fill_busy   <= 1'b0;
                tmo         <= !reach;
                if (dose_after_fill) begin
                  st <= S_VA;
                end else begin
                  status <= reach ? ST_OK : ST_TIMEOUT;
                  st     <= S_PUMP;
                end
              end else begin
                status <= ST_OK;
                st     <= S_PUMP;
              end
            end
          endcase
        end
        S_VA:  st <= S_UA;
        S_UA:  st <= S_VB;
        S_VB:  st <= S_UB;
        S_UB:  st <= S_DIV;
        S_DIV: st <= S_REC;
        S_REC: st <= S_ML;
        S_ML: begin
          shown_dose <= sat ? {ML_W{1'b1}} : prod[RECIP_SH+ML_W-1:RECIP_SH];
          st         <= S_CHK;
        end
        S_CHK: begin
          if (dose_busy) begin
            status <= tmo ? ST_TIMEOUT : ST_BUSY;
            st     <= S_PUMP;
          end else if (shown_dose < DOSE_MIN) begin
            status <= tmo ? ST_TIMEOUT : ST_SMALL;
            st     <= S_PUMP;
          end else begin
            status    <= tmo ? ST_TIMEOUT : ST_OK;
            dose_busy <= 1'b1;
            st        <= S_DUR;
          end
        end
        S_DUR: begin
          pump_duration <= DUR_W'(dead_time_ms) + DUR_W'(prod[DUR_SHIFT+DUR_W-2:DUR_SHIFT]);
          st            <= (c_act == ACT_TICK) ? S_PUMP : S_DONE;
        end
        S_PUMP: begin
          st <= S_DONE;
          if (dose_busy) begin
            if (!pump_running) begin
              pump_running <= 1'b1;
              active_pump  <= '0;
              switch_time  <= c_now;
            end else if (pump_expired) begin
              if (active_pump >= LAST_PUMP) begin
                pump_running <= 1'b0;
                dose_busy    <= 1'b0;
                active_pump  <= '0;
              end else begin
                active_pump <= active_pump + PUMP_W'(1);
              end
              switch_time <= c_now;
            end
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp.ready) st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> !cmd.ready)
    else $error("command taken while one is in progress");

  a_pump_in_dose: assert property (@(posedge clk) disable iff (rst)
    pump_running |-> dose_busy)
    else $error("pump running outside a dose sequence");

  a_valve_in_fill: assert property (@(posedge clk) disable iff (rst)
    valve_state |-> fill_busy)
    else $error("valve open outside a fill sequence");

  a_pump_idle: assert property (@(posedge clk) disable iff (rst)
    !pump_running |-> active_pump == '0)
    else $error("pump index set while no pump runs");

endmodule

// ===== bench/tb_tank_fill_and_dose_sequencer_unit.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the tank fill and dose sequencer: fill/dose commands vs a behavioral model.
module tb_tank_fill_and_dose_sequencer_unit;
  import tfd_pkg::*;

  localparam int N_PUMPS      = 4;
  localparam int LIMIT_CYCLES = 600000;
  localparam int SETTLE       = 20;
  localparam int HOLD_CYCLES  = 400;

  localparam longint VOL_PER_LEVEL = 332;
  localparam longint VOL_EMPTY     = 6608;
  localparam logic [63:0] UNITS_PER_ML = 64'd409600;
  localparam logic [63:0] DOSE_SAT     = 64'd65535;
  localparam logic [ML_W-1:0] MIN_DOSE = 16'd30;

  typedef struct {
    logic [ACT_W-1:0]   action;
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] target;
    logic [ML_W-1:0]    amount;
    logic [TIME_W-1:0]  now;
    logic               ok;
  } cmd_t;

  typedef struct {
    logic              valve_open;
    logic              filling;
    logic              dosing;
    logic              pump_on;
    logic [PUMP_W-1:0] pump_number;
    logic [STAT_W-1:0] status;
    logic [ML_W-1:0]   dose_ml;
  } panel_t;

  logic clk = 1'b0;
  logic rst;

  tfd_cfg_if cfg_ch ();
  tfd_cmd_if cmd_ch ();
  tfd_rsp_if rsp_ch ();

  tank_fill_and_dose_sequencer_unit #(.NUM_PUMPS(N_PUMPS)) dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch),
    .cmd(cmd_ch),
    .rsp(rsp_ch)
  );

  // register mirror
  logic [LEVEL_W-1:0] cfg_height;
  logic [FILL_W-1:0]  cfg_max_fill;
  logic [ML_W-1:0]    cfg_ml_per_l;
  logic [ML_W-1:0]    cfg_dead;
  logic [ML_W-1:0]    cfg_ms_per_ml;

  // sequencer state
  logic               fill_on, dose_next, valve_on, dose_on, pump_run;
  logic [LEVEL_W-1:0] goal_lvl, base_lvl;
  logic [TIME_W-1:0]  fill_t0, pump_ms, pump_t0;
  logic [PUMP_W-1:0]  pump_idx;
  logic [ML_W-1:0]    dose_shown;

  cmd_t   pending_cmds[$];
  panel_t predicted_panels[$];
  cmd_t   cur_cmd;

  int n_queued = 0;
  int n_acc = 0;
  int n_rsp = 0;
  int n_err = 0;
  int n_cycles = 0;
  int status_seen[8];
  int tx_wait = 0;
  int rx_wait = 0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  int hold_left = 0;
  int hold_count = 0;
  int sim_level = 0;
  logic [TIME_W-1:0] clock_ms = '0;

  initial forever #10 clk = ~clk;

  function automatic logic [63:0] nutrient_of(logic [LEVEL_W-1:0] lvl);
    longint vol;
    vol = longint'(lvl) * VOL_PER_LEVEL - VOL_EMPTY;
    if (vol < 0) vol = 0;
    return 64'(vol) * 64'(cfg_ml_per_l);
  endfunction

  function automatic logic [STAT_W-1:0] try_dose(logic [ML_W-1:0] ml);
    logic [63:0] t;
    if (dose_on) return ST_BUSY;
    if (ml < MIN_DOSE) return ST_SMALL;
    dose_on = 1'b1;
    t = 64'(ml) * 64'(cfg_ms_per_ml);
    pump_ms = 32'(cfg_dead) + t[39:8];
    return ST_OK;
  endfunction

  function automatic logic [STAT_W-1:0] close_fill(logic [LEVEL_W-1:0] lvl);
    logic [63:0] end_units, base_units, ml;
    valve_on = 1'b0;
    fill_on = 1'b0;
    if (!dose_next) return ST_OK;
    end_units = nutrient_of(lvl);
    base_units = nutrient_of(base_lvl);
    ml = '0;
    if (end_units > base_units) ml = (end_units - base_units) / UNITS_PER_ML;
    if (ml > DOSE_SAT) ml = DOSE_SAT;
    dose_shown = ml[ML_W-1:0];
    return try_dose(ml[ML_W-1:0]);
  endfunction

  function automatic panel_t advance_sequencer(cmd_t c);
    panel_t p;
    logic [STAT_W-1:0] st;
    st = ST_OK;
    if (c.action == ACT_FILL || c.action == ACT_FILL_DOSE) begin
      if (fill_on) begin
        st = ST_BUSY;
      end else if (c.target < c.level || c.target > cfg_height) begin
        st = ST_BAD_LEVEL;
      end else begin
        dose_next = (c.action == ACT_FILL_DOSE);
        fill_on = 1'b1;
        goal_lvl = c.target;
      end
    end else if (c.action == ACT_DOSE) begin
      st = try_dose(c.amount);
    end else begin
      if (fill_on) begin
        if (!valve_on) begin
          if (c.ok) begin
            valve_on = 1'b1;
            fill_t0 = c.now;
            base_lvl = c.level;
          end else begin
            fill_on = 1'b0;
            st = ST_SERVER;
          end
        end else begin
          if (c.level >= goal_lvl) st = close_fill(c.level);
          if (fill_on && 32'(c.now - fill_t0) > 32'(cfg_max_fill)) begin
            void'(close_fill(c.level));
            st = ST_TIMEOUT;
          end
        end
      end
      if (dose_on) begin
        if (!pump_run) begin
          pump_run = 1'b1;
          pump_idx = '0;
          pump_t0 = c.now;
        end
        if (32'(c.now - pump_t0) > pump_ms) begin
          if (int'(pump_idx) >= N_PUMPS - 1) begin
            pump_run = 1'b0;
            dose_on = 1'b0;
            pump_idx = '0;
          end else begin
            pump_idx++;
          end
          pump_t0 = c.now;
        end
      end
    end
    p.valve_open = valve_on;
    p.filling = fill_on;
    p.dosing = dose_on;
    p.pump_on = pump_run;
    p.pump_number = pump_run ? pump_idx : '0;
    p.status = st;
    p.dose_ml = dose_shown;
    status_seen[st]++;
    return p;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_err++;
    end
  endfunction

  function automatic void push_cmd(int act, int lvl, int tgt, int amt, logic [TIME_W-1:0] now,
                                   int ok);
    cmd_t c;
    c.action = ACT_W'(act);
    c.level = LEVEL_W'(lvl);
    c.target = LEVEL_W'(tgt);
    c.amount = ML_W'(amt);
    c.now = now;
    c.ok = ok[0];
    pending_cmds.push_back(c);
    n_queued++;
  endfunction

  function automatic logic [TIME_W-1:0] next_now();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick >= 98) clock_ms += $urandom;
    else if (pick >= 88) clock_ms += $urandom_range(3000, 2000000);
    else if (pick >= 10) clock_ms += $urandom_range(1, 3000);
    return clock_ms;
  endfunction

  task automatic gen_fill();
    int tgt, rise, steps;
    int act;
    act = $urandom_range(0, 1) ? int'(ACT_FILL_DOSE) : int'(ACT_FILL);
    if ($urandom_range(0, 3) == 0) sim_level = $urandom_range(0, sim_level);
    if ($urandom_range(0, 9) == 0) sim_level = 0;
    if ($urandom_range(0, 5) == 0) tgt = $urandom_range(0, 4095);
    else tgt = sim_level + $urandom_range(0, 300);
    if (tgt > int'(cfg_height) && $urandom_range(0, 3) != 0) tgt = cfg_height;
    if (tgt > 4095) tgt = 4095;
    push_cmd(act, sim_level, tgt, $urandom, next_now(), $urandom);
    push_cmd(ACT_TICK, sim_level, $urandom, $urandom, next_now(), $urandom_range(0, 7) != 0);
    steps = 0;
    while (sim_level < tgt && steps < 30) begin
      rise = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 800) : $urandom_range(0, 40);
      sim_level = (sim_level + rise > 4095) ? 4095 : sim_level + rise;
      if ($urandom_range(0, 11) == 0)
        push_cmd($urandom_range(1, 3), sim_level, $urandom, $urandom, next_now(), $urandom);
      push_cmd(ACT_TICK, sim_level, $urandom, $urandom, next_now(), $urandom);
      steps++;
    end
    repeat ($urandom_range(0, 6))
      push_cmd(ACT_TICK, sim_level, $urandom, $urandom, next_now(), $urandom);
  endtask

  task automatic gen_dose();
    int pick, amt;
    pick = $urandom_range(0, 9);
    if (pick < 2) amt = $urandom_range(0, 29);
    else if (pick < 3) amt = $urandom_range(0, 65535);
    else amt = $urandom_range(30, 1500);
    push_cmd(ACT_DOSE, $urandom, $urandom, amt, next_now(), $urandom);
    repeat ($urandom_range(2, 14))
      push_cmd(ACT_TICK, sim_level, $urandom, $urandom, next_now(), $urandom);
  endtask

  task automatic gen_random(int n);
    int first, pick;
    first = n_queued;
    while (n_queued - first < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        gen_fill();
      end else if (pick < 80) begin
        gen_dose();
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 8))
          push_cmd(ACT_TICK, sim_level, $urandom, $urandom, next_now(), $urandom);
      end else begin
        push_cmd($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || cmd_ch.valid || predicted_panels.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_ch.index <= idx;
    cfg_ch.data <= CDATA_W'(val);
    cfg_ch.valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_HEIGHT:    cfg_height = LEVEL_W'(val);
      REG_MAX_FILL:  cfg_max_fill = FILL_W'(val);
      REG_ML_PER_L:  cfg_ml_per_l = ML_W'(val);
      REG_DEAD:      cfg_dead = ML_W'(val);
      REG_MS_PER_ML: cfg_ms_per_ml = ML_W'(val);
      default: ;
    endcase
  endtask

  task automatic write_all(int unsigned h, int unsigned mf, int unsigned mpl, int unsigned dt,
                           int unsigned mpm);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_MAX_FILL, mf);
    write_reg(REG_ML_PER_L, mpl);
    write_reg(REG_DEAD, dt);
    write_reg(REG_MS_PER_ML, mpm);
    @(negedge clk);
  endtask

  // command driver
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        predicted_panels.push_back(advance_sequencer(cur_cmd));
        n_acc <= n_acc + 1;
        if ($urandom_range(0, 40) == 0) tx_quiet = !tx_quiet;
        tx_wait = tx_quiet ? 0 : $urandom_range(0, 12);
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          cmd_ch.valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          cur_cmd = pending_cmds.pop_front();
          cmd_ch.action <= cur_cmd.action;
          cmd_ch.level <= cur_cmd.level;
          cmd_ch.target_level <= cur_cmd.target;
          cmd_ch.dose_amount <= cur_cmd.amount;
          cmd_ch.now_ms <= cur_cmd.now;
          cmd_ch.server_ok <= cur_cmd.ok;
          cmd_ch.valid <= 1'b1;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor
  always @(posedge clk) begin
    panel_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        n_rsp++;
        if (predicted_panels.size() == 0) begin
          $error("response transaction with nothing expected");
          n_err++;
        end else begin
          want = predicted_panels.pop_front();
          check_field("valve_open", want.valve_open, rsp_ch.valve_open);
          check_field("filling", want.filling, rsp_ch.filling);
          check_field("dosing", want.dosing, rsp_ch.dosing);
          check_field("pump_on", want.pump_on, rsp_ch.pump_on);
          check_field("pump_number", want.pump_number, rsp_ch.pump_number);
          check_field("status", want.status, rsp_ch.status);
          check_field("dose_ml", want.dose_ml, rsp_ch.dose_ml);
        end
        if ($urandom_range(0, 40) == 0) rx_quiet = !rx_quiet;
        rx_wait = rx_quiet ? 0 : $urandom_range(0, 12);
      end
      if (hold_left != 0) begin
        rsp_ch.ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // long receiver hold-off, twice per run
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_count < 2 && n_acc >= (hold_count + 1) * 500) begin
      hold_left <= HOLD_CYCLES;
      hold_count <= hold_count + 1;
    end
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [TIME_W-1:0] t;
    rst = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.action = ACT_TICK;
    cmd_ch.level = '0;
    cmd_ch.target_level = '0;
    cmd_ch.dose_amount = '0;
    cmd_ch.now_ms = '0;
    cmd_ch.server_ok = 1'b0;
    rsp_ch.ready = 1'b0;
    for (int i = 0; i < 8; i++) status_seen[i] = 0;
    cfg_height = 12'd1600;
    cfg_max_fill = 24'd600000;
    cfg_ml_per_l = 16'd512;
    cfg_dead = 16'd2000;
    cfg_ms_per_ml = 16'd256;
    {fill_on, dose_next, valve_on, dose_on, pump_run} = '0;
    goal_lvl = '0;
    base_lvl = '0;
    fill_t0 = '0;
    pump_ms = '0;
    pump_t0 = '0;
    pump_idx = '0;
    dose_shown = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // rejects, then a long dose walking through every pump
    push_cmd(ACT_TICK, 0, 0, 0, 0, 0);
    push_cmd(ACT_FILL, 100, 50, 0, 0, 1);
    push_cmd(ACT_FILL, 0, 4095, 0, 0, 1);
    push_cmd(ACT_DOSE, 0, 0, 29, 0, 0);
    push_cmd(ACT_DOSE, 0, 0, 65535, 0, 0);
    push_cmd(ACT_DOSE, 0, 0, 30, 0, 0);
    t = 32'd1000;
    push_cmd(ACT_TICK, 0, 0, 0, t, 0);
    push_cmd(ACT_TICK, 0, 0, 0, t + 32'd67535, 0);
    repeat (4) begin
      t += 32'd67536;
      push_cmd(ACT_TICK, 0, 0, 0, t, 0);
    end
    // busy fill, server failure, fill-then-dose across time wrap
    push_cmd(ACT_FILL, 0, 1600, 0, t, 1);
    push_cmd(ACT_FILL_DOSE, 0, 1600, 0, t, 1);
    push_cmd(ACT_TICK, 0, 0, 0, t, 0);
    push_cmd(ACT_FILL_DOSE, 20, 1600, 0, t, 1);
    push_cmd(ACT_TICK, 20, 0, 0, 32'hFFFF_FF00, 1);
    push_cmd(ACT_TICK, 1599, 0, 0, 32'h0000_0100, 1);
    push_cmd(ACT_TICK, 1600, 0, 0, 32'h0000_0200, 1);
    // valve closes without server ack; fill ends while a dose runs
    push_cmd(ACT_FILL, 0, 0, 0, 32'h300, 1);
    push_cmd(ACT_TICK, 0, 0, 0, 32'h300, 1);
    push_cmd(ACT_TICK, 0, 0, 0, 32'h400, 0);
    push_cmd(ACT_FILL_DOSE, 10, 11, 0, 32'h500, 1);
    push_cmd(ACT_TICK, 10, 0, 0, 32'h500, 1);
    push_cmd(ACT_TICK, 4095, 0, 0, 32'h600, 1);
    // fill timeout
    push_cmd(ACT_FILL, 0, 100, 0, 32'h1000, 1);
    push_cmd(ACT_TICK, 0, 0, 0, 32'h1000, 1);
    push_cmd(ACT_TICK, 5, 0, 0, 32'h1000 + 32'd600001, 1);
    clock_ms = 32'h1000 + 32'd600001;
    sim_level = 5;
    gen_random(320);
    wait_idle();

    write_all(4095, 0, 65535, 0, 0);
    gen_random(250);
    wait_idle();

    write_all(0, 16777215, 0, 65535, 65535);
    gen_random(200);
    wait_idle();

    write_all($urandom_range(800, 4095), $urandom_range(1000, 2000000), $urandom_range(0, 65535),
              $urandom_range(0, 65535), $urandom_range(0, 65535));
    clock_ms = 32'hFFFF_0000;
    gen_random(330);
    wait_idle();

    write_all($urandom_range(0, 4095), $urandom_range(0, 16777215), $urandom_range(0, 65535),
              $urandom_range(0, 65535), $urandom_range(0, 65535));
    gen_random(320);
    wait_idle();

    $display("Run: %0d commands, %0d responses checked, 5 register settings, %0d receiver holds",
             n_acc, n_rsp, hold_count);
    $display("Status ok/busy/bad level/small/server/timeout: %0d/%0d/%0d/%0d/%0d/%0d",
             status_seen[ST_OK], status_seen[ST_BUSY], status_seen[ST_BAD_LEVEL],
             status_seen[ST_SMALL], status_seen[ST_SERVER], status_seen[ST_TIMEOUT]);
    if (n_err == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tfd_pkg.sv
rtl/tfd_if.sv
rtl/tank_fill_and_dose_sequencer_unit.sv
bench/tb_tank_fill_and_dose_sequencer_unit.sv
